// File: rtl/x86e_pkg.sv
// Shared types, opcode constants and the request encoder for the x86-64 encoder.
// No dependencies; used by every module of the block.
package x86e_pkg;

   // request kinds
   typedef enum logic [1:0] {
      CMD_UD2     = 2'd0,
      CMD_MOV_IMM = 2'd1,
      CMD_MOV_REG = 2'd2,
      CMD_ADD_IMM = 2'd3
   } cmd_type;

   // operand sizes
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;
   localparam logic [1:0] SIZE_QWORD = 2'd3;

   // opcode and prefix bytes
   localparam logic [7:0] OP_ESC      = 8'h0F;
   localparam logic [7:0] OP_UD2      = 8'h0B;
   localparam logic [7:0] PFX_OPSIZE  = 8'h66;
   localparam logic [7:0] REX_BASE    = 8'h40;
   localparam logic [7:0] REX_B       = 8'h41;
   localparam logic [7:0] REX_W       = 8'h48;
   localparam logic [7:0] REX_WB      = 8'h49;
   localparam logic [7:0] OP_MOV_RM_I = 8'hC7;
   localparam logic [7:0] OP_MOV_R_I  = 8'hB8;
   localparam logic [7:0] OP_MOV_R8_I = 8'hB0;
   localparam logic [7:0] OP_MOV_RM_R = 8'h89;
   localparam logic [7:0] OP_MOV_RM8  = 8'h88;
   localparam logic [7:0] OP_ADD_I8S  = 8'h83;
   localparam logic [7:0] OP_ADD_I    = 8'h81;
   localparam logic [7:0] OP_ADD_I8   = 8'h80;
   localparam logic [7:0] OP_ADD_AX_I = 8'h05;
   localparam logic [7:0] OP_ADD_AL_I = 8'h04;
   localparam logic [7:0] MODRM_REG   = 8'hC0;

   localparam logic [63:0] IMM32_MAX = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] IMM8_MAX  = 64'h0000_0000_0000_007F;

   localparam int HDR_MAX = 4;

   // one classified instruction: up to four opcode bytes, then immediate bytes
   typedef struct packed {
      logic [HDR_MAX-1:0][7:0] hdr;      // hdr[0] goes out first
      logic [2:0]              hdr_cnt;  // 1..4
      logic [63:0]             imm;      // little-endian, low byte first
      logic [3:0]              imm_cnt;  // 0..8
   } desc_type;

   // build the descriptor for one request
   function automatic desc_type encode(input logic [1:0] cmd, input logic [1:0] size,
                                       input logic [3:0] d, input logic [3:0] s,
                                       input logic [63:0] imm);
      desc_type   r;
      logic [2:0] n;
      logic [7:0] lo;
      logic [7:0] rex;
      logic [63:0] v;
      logic [3:0] wide;
      logic       ext;
      r         = '0;
      n         = 3'd0;
      lo        = {5'd0, d[2:0]};
      ext       = d[3];
      rex       = REX_BASE | {5'd0, s[3], 1'b0, d[3]};
      r.imm     = imm;
      v         = imm;
      wide      = 4'd4;
      case (cmd_type'(cmd))
         CMD_UD2: begin
            r.hdr[0] = OP_ESC;
            r.hdr[1] = OP_UD2;
            n = 3'd2;
         end
         CMD_MOV_IMM: begin
            case (size)
               SIZE_QWORD: begin
                  r.hdr[0] = ext ? REX_WB : REX_W;
                  if (imm <= IMM32_MAX) begin
                     r.hdr[1] = OP_MOV_RM_I;
                     r.hdr[2] = MODRM_REG | lo;
                     n = 3'd3;
                     r.imm_cnt = 4'd4;
                  end else begin
                     r.hdr[1] = OP_MOV_R_I | lo;
                     n = 3'd2;
                     r.imm_cnt = 4'd8;
                  end
               end
               SIZE_DWORD: begin
                  if (ext) begin
                     r.hdr[n[1:0]] = REX_B;
                     n = n + 3'd1;
                  end
                  r.hdr[n[1:0]] = OP_MOV_R_I | lo;
                  n = n + 3'd1;
                  r.imm_cnt = 4'd4;
               end
               SIZE_WORD: begin
                  r.hdr[0] = PFX_OPSIZE;
                  n = 3'd1;
                  if (ext) begin
                     r.hdr[n[1:0]] = REX_B;
                     n = n + 3'd1;
                  end
                  r.hdr[n[1:0]] = OP_MOV_R_I | lo;
                  n = n + 3'd1;
                  r.imm_cnt = 4'd2;
               end
               default: begin
                  if (ext) begin
                     r.hdr[n[1:0]] = REX_B;
                     n = n + 3'd1;
                  end
                  r.hdr[n[1:0]] = OP_MOV_R8_I | lo;
                  n = n + 3'd1;
                  r.imm_cnt = 4'd1;
               end
            endcase
         end
         CMD_MOV_REG: begin
            case (size)
               SIZE_QWORD: begin
                  r.hdr[0] = rex | 8'h08;
                  n = 3'd1;
               end
               SIZE_BYTE: begin
                  // SPL..DIL need a bare REX
                  if (s[3] || d[3] || s[2] || d[2]) begin
                     r.hdr[0] = rex;
                     n = 3'd1;
                  end
               end
               default: begin
                  if (size == SIZE_WORD) begin
                     r.hdr[0] = PFX_OPSIZE;
                     n = 3'd1;
                  end
                  if (s[3] || d[3]) begin
                     r.hdr[n[1:0]] = rex;
                     n = n + 3'd1;
                  end
               end
            endcase
            r.hdr[n[1:0]] = (size == SIZE_BYTE) ? OP_MOV_RM8 : OP_MOV_RM_R;
            n = n + 3'd1;
            r.hdr[n[1:0]] = MODRM_REG | {2'd0, s[2:0], d[2:0]};
            n = n + 3'd1;
         end
         default: begin
            if (size == SIZE_BYTE) begin
               if (d == 4'd0) begin
                  r.hdr[0] = OP_ADD_AL_I;
                  n = 3'd1;
               end else begin
                  if (ext) begin
                     r.hdr[n[1:0]] = REX_B;
                     n = n + 3'd1;
                  end
                  r.hdr[n[1:0]] = OP_ADD_I8;
                  n = n + 3'd1;
                  r.hdr[n[1:0]] = MODRM_REG | lo;
                  n = n + 3'd1;
               end
               r.imm_cnt = 4'd1;
            end else begin
               // prefixes and the operand value the short-form test sees
               if (size == SIZE_QWORD) begin
                  r.hdr[0] = ext ? REX_WB : REX_W;
                  n = 3'd1;
               end else if (size == SIZE_DWORD) begin
                  v = {32'd0, imm[31:0]};
                  if (ext) begin
                     r.hdr[0] = REX_B;
                     n = 3'd1;
                  end
               end else begin
                  v = {48'd0, imm[15:0]};
                  wide = 4'd2;
                  r.hdr[0] = PFX_OPSIZE;
                  n = 3'd1;
                  if (ext) begin
                     r.hdr[n[1:0]] = REX_B;
                     n = n + 3'd1;
                  end
               end
               if (v <= IMM8_MAX) begin
                  r.hdr[n[1:0]] = OP_ADD_I8S;
                  n = n + 3'd1;
                  r.hdr[n[1:0]] = MODRM_REG | lo;
                  n = n + 3'd1;
                  r.imm_cnt = 4'd1;
               end else if (d == 4'd0) begin
                  r.hdr[n[1:0]] = OP_ADD_AX_I;
                  n = n + 3'd1;
                  r.imm_cnt = wide;
               end else begin
                  r.hdr[n[1:0]] = OP_ADD_I;
                  n = n + 3'd1;
                  r.hdr[n[1:0]] = MODRM_REG | lo;
                  n = n + 3'd1;
                  r.imm_cnt = wide;
               end
            end
         end
      endcase
      r.hdr_cnt = n;
      return r;
   endfunction

endpackage

// File: rtl/x86e_front.sv
// Front end: unpacks a request word and classifies it into an instruction descriptor.
// Depends on x86e_pkg (desc_type, encode).
module x86e_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,
   output logic                 push_valid,
   input  logic                 push_ready,
   output x86e_pkg::desc_type   push_desc
);
   import x86e_pkg::*;

   logic [1:0]  cmd;
   logic [1:0]  op_size;
   logic [3:0]  dest_reg;
   logic [3:0]  src_reg;
   logic [63:0] imm_value;
   logic        seen_ff;
   logic        seen_in;

   // field unpack
   assign cmd       = req_tdata[1:0];
   assign op_size   = req_tdata[3:2];
   assign dest_reg  = req_tdata[7:4];
   assign src_reg   = req_tdata[11:8];
   assign imm_value = req_tdata[75:12];

   // hold off accepting until the registered seen flag is set after reset is released
   assign seen_in = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   assign push_valid = req_tvalid && seen_ff;
   assign req_tready = push_ready && seen_ff;
   assign push_desc  = encode(cmd, op_size, dest_reg, src_reg, imm_value);
endmodule

// File: rtl/x86e_fifo.sv
// Two-entry descriptor queue between the classifier and the byte serializer.
// Depends on x86e_pkg (desc_type).
module x86e_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  x86e_pkg::desc_type   push_desc,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output x86e_pkg::desc_type   pop_desc
);
   import x86e_pkg::*;

   desc_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_desc   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end
endmodule

// File: rtl/x86e_back.sv
// Back end: shifts a descriptor out one code byte per word, marking the last byte.
// Depends on x86e_pkg (desc_type).
module x86e_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  x86e_pkg::desc_type   pop_desc,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import x86e_pkg::*;

   logic [HDR_MAX-1:0][7:0] hdr_ff;
   logic [HDR_MAX-1:0][7:0] hdr_in;
   logic [2:0]              hdr_left_ff;
   logic [2:0]              hdr_left_in;
   logic [63:0]             imm_ff;
   logic [63:0]             imm_in;
   logic [3:0]              imm_left_ff;
   logic [3:0]              imm_left_in;
   logic                    busy_ff;
   logic                    busy_in;
   logic                    fire;
   logic                    last;
   logic                    load;

   // current byte: header bytes first, then immediate low byte first
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = (hdr_left_ff != 3'd0) ? hdr_ff[0] : imm_ff[7:0];
   assign last       = ((hdr_left_ff == 3'd1) && (imm_left_ff == 4'd0)) ||
                       ((hdr_left_ff == 3'd0) && (imm_left_ff == 4'd1));
   assign rsp_tlast  = last;
   assign fire       = busy_ff && rsp_tready;
   assign load       = pop_valid && (!busy_ff || (fire && last));
   assign pop_ready  = !busy_ff || (fire && last);

   // shift or reload
   always_comb begin
      hdr_in      = hdr_ff;
      hdr_left_in = hdr_left_ff;
      imm_in      = imm_ff;
      imm_left_in = imm_left_ff;
      busy_in     = busy_ff;
      if (load) begin
         hdr_in      = pop_desc.hdr;
         hdr_left_in = pop_desc.hdr_cnt;
         imm_in      = pop_desc.imm;
         imm_left_in = pop_desc.imm_cnt;
         busy_in     = 1'b1;
      end else if (fire) begin
         if (last) begin
            busy_in = 1'b0;
         end
         if (hdr_left_ff != 3'd0) begin
            hdr_in      = hdr_ff >> 8;
            hdr_left_in = hdr_left_ff - 3'd1;
         end else begin
            imm_in      = imm_ff >> 8;
            imm_left_in = imm_left_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         hdr_left_ff <= 3'd0;
         imm_left_ff <= 4'd0;
      end else begin
         busy_ff     <= busy_in;
         hdr_left_ff <= hdr_left_in;
         imm_left_ff <= imm_left_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      imm_ff <= imm_in;
   end
endmodule

// File: rtl/x86_64_instruction_encoder_top.sv
// Top level of the x86-64 instruction encoder: classifier, queue and byte serializer.
// Depends on x86e_pkg, x86e_front, x86e_fifo, x86e_back.
//
// Each request word names one instruction (UD2, mov imm, mov reg, add imm) at
// 8/16/32/64 bits; the block answers with its machine code, one byte per
// rsp word, with rsp_tlast on the final byte. An instruction is 2 bytes (UD2)
// up to 10 bytes (a 64-bit move of a wide immediate) long; the byte serializer,
// which sends one byte a cycle while rsp_tready is high, sets the rate,
// and bytes of consecutive instructions follow with no gap. The classifier
// encodes a request in the cycle it is accepted and parks it in a two-entry
// queue, so up to two requests can be taken while the current one drains.
module x86_64_instruction_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], op_size[3:2], dest_reg[7:4], src_reg[11:8], imm_value[75:12], zero pad
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // code_byte[7:0]
   output logic [7:0]  rsp_tdata,
   // last_byte
   output logic        rsp_tlast
);
   import x86e_pkg::*;

   logic     push_valid;
   logic     push_ready;
   desc_type push_desc;
   logic     pop_valid;
   logic     pop_ready;
   desc_type pop_desc;

   x86e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   x86e_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   x86e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
